>>> hw/rtl/bpwdt_pkg.sv
// Package for the pixel write engine with depth test.
// Holds register index codes, mode codes, field widths and pipeline stage types.
// No dependencies.
package bpwdt_pkg;

    // Field and datapath widths
    localparam int unsigned VAL_W      = 16;
    localparam int unsigned OUT_ADDR_W = 24;
    localparam int unsigned SOFF_W     = 23;
    localparam int unsigned CNT_W      = 10;
    localparam int unsigned POS_W      = 11;
    localparam int unsigned PROD_W     = 23;
    localparam int unsigned SROW_W     = 21;
    localparam int unsigned SUM_W      = 25;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WIDTH    = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_PIXEL_TYPE   = 3'd2,
        CFG_Z_MODE       = 3'd3,
        CFG_SOURCE_MODE  = 3'd4,
        CFG_DIRECT_VALUE = 3'd5,
        CFG_X_INFO       = 3'd6,
        CFG_Y_INFO       = 3'd7
    } cfg_index_t;

    // Depth test modes: the write is suppressed when the test holds
    typedef enum logic [2:0] {
        ZM_ALWAYS     = 3'd0,
        ZM_LT         = 3'd1,
        ZM_EQ         = 3'd2,
        ZM_LE         = 3'd3,
        ZM_GT         = 3'd4,
        ZM_NE         = 3'd5,
        ZM_GE         = 3'd6,
        ZM_COLOR_ONLY = 3'd7
    } z_mode_t;

    // Source modes (bit 1 set means direct values from the register)
    localparam logic [1:0] SM_STEP   = 2'd0;
    localparam logic [1:0] SM_DUP    = 2'd1;
    localparam logic [1:0] SM_DIRECT = 2'd2;

    // Pixel type thresholds for plane selection
    localparam logic [3:0] PT_MAP_HI = 4'd13;
    localparam logic [3:0] PT_MAP_LO = 4'd9;

    // Input register contents
    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic             empty;
        logic             last;
        logic [VAL_W-1:0] color;
        logic [VAL_W-1:0] depth;
        logic             cw;
        logic             dw;
    } s1_t;

    // Product stage contents
    typedef struct packed {
        logic [PROD_W-1:0] c_plane;
        logic [PROD_W-1:0] z_plane;
        logic [PROD_W-1:0] pos_prod;
        logic [SROW_W-1:0] src_prod;
        logic [CNT_W-1:0]  col;
        logic              empty;
        logic              last;
        logic [VAL_W-1:0]  color;
        logic [VAL_W-1:0]  depth;
        logic              cw;
        logic              dw;
    } s2_t;

endpackage

>>> hw/rtl/block_pixel_write_with_depth_test_unit.sv
// Top level of the rectangle pixel write engine with depth test.
// Depends on bpwdt_pkg for codes, widths and stage types.
//
// One pixel request is accepted every cycle unless a result waits, and passes in order
// through an input register holding the counter position, depth test outcome and
// values, a product stage with the plane base and row offset multipliers, and an
// output register where the addresses are summed. Backpressure on the result
// channel stalls the whole pipeline; s_ready is low only while a result waits.
// Column and row counters advance at accept, so throughput is one pixel per
// cycle. Configuration is taken at any time through the cfg channel
// (cfg_ready is always high) and must only change while the engine is drained.
module block_pixel_write_with_depth_test_unit #(
    parameter int unsigned ADDR_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // pixel request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_source_color,
    input  logic [15:0] s_source_depth,
    input  logic [15:0] s_target_depth,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_color_address,
    output logic [23:0] m_depth_address,
    output logic [22:0] m_source_offset,
    output logic [15:0] m_color_out,
    output logic [15:0] m_depth_out,
    output logic        m_color_write,
    output logic        m_depth_write,
    output logic        m_last_pixel
);

    // Configuration registers
    logic [10:0] row_width_reg;
    logic [9:0]  frame_height_reg;
    logic [3:0]  pixel_type_reg;
    logic [2:0]  z_mode_reg;
    logic [1:0]  source_mode_reg;
    logic [31:0] direct_value_reg;
    logic [25:0] x_info_reg;
    logic [25:0] y_info_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg    <= '0;
            frame_height_reg <= '0;
            pixel_type_reg   <= '0;
            z_mode_reg       <= '0;
            source_mode_reg  <= '0;
            direct_value_reg <= '0;
            x_info_reg       <= '0;
            y_info_reg       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bpwdt_pkg::CFG_ROW_WIDTH:    row_width_reg    <= cfg_data[10:0];
                bpwdt_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[9:0];
                bpwdt_pkg::CFG_PIXEL_TYPE:   pixel_type_reg   <= cfg_data[3:0];
                bpwdt_pkg::CFG_Z_MODE:       z_mode_reg       <= cfg_data[2:0];
                bpwdt_pkg::CFG_SOURCE_MODE:  source_mode_reg  <= cfg_data[1:0];
                bpwdt_pkg::CFG_DIRECT_VALUE: direct_value_reg <= cfg_data;
                bpwdt_pkg::CFG_X_INFO:       x_info_reg       <= cfg_data[25:0];
                bpwdt_pkg::CFG_Y_INFO:       y_info_reg       <= cfg_data[25:0];
                default: ;
            endcase
        end
    end

    // Decoded configuration fields
    logic [10:0] width;
    logic [9:0]  xlen;
    logic [9:0]  ylen;
    logic [10:0] xpos;
    logic [10:0] ypos;
    logic        color_only;

    assign width      = {row_width_reg[10:3], 3'b000};
    assign xlen       = x_info_reg[25:16];
    assign xpos       = x_info_reg[10:0];
    assign ylen       = y_info_reg[25:16];
    assign ypos       = y_info_reg[10:0];
    assign color_only = (z_mode_reg == bpwdt_pkg::ZM_COLOR_ONLY);

    // Pipeline control: all stages advance together unless a result waits
    logic           adv;
    logic           accept;
    logic           s1_valid_reg;
    logic           s2_valid_reg;
    logic           m_valid_reg;
    bpwdt_pkg::s1_t s1_reg, s1_next;
    bpwdt_pkg::s2_t s2_reg, s2_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Counters
    logic [9:0] col_count_reg, col_count_next;
    logic [9:0] row_count_reg, row_count_next;

    // Input stage: position, depth test and values
    logic        in_empty;
    logic [9:0]  in_col;
    logic [9:0]  in_row;
    logic [15:0] src_c;
    logic [15:0] src_z;
    logic        hit;
    logic        col_wrap;
    logic        row_wrap;

    always_comb begin
        in_empty = (xlen == '0) || (ylen == '0);
        in_col   = in_empty ? '0 : col_count_reg;
        in_row   = in_empty ? '0 : row_count_reg;
        src_c    = source_mode_reg[1] ? direct_value_reg[31:16] : s_source_color;
        src_z    = source_mode_reg[1] ? direct_value_reg[15:0]  : s_source_depth;

        case (z_mode_reg)
            bpwdt_pkg::ZM_LT: hit = s_target_depth <  src_z;
            bpwdt_pkg::ZM_EQ: hit = s_target_depth == src_z;
            bpwdt_pkg::ZM_LE: hit = s_target_depth <= src_z;
            bpwdt_pkg::ZM_GT: hit = s_target_depth >  src_z;
            bpwdt_pkg::ZM_NE: hit = s_target_depth != src_z;
            bpwdt_pkg::ZM_GE: hit = s_target_depth >= src_z;
            default:          hit = 1'b0;
        endcase

        col_wrap = ({1'b0, in_col} + 11'd1) >= {1'b0, xlen};
        row_wrap = ({1'b0, in_row} + 11'd1) >= {1'b0, ylen};

        s1_next.col   = in_col;
        s1_next.row   = in_row;
        s1_next.empty = in_empty;
        s1_next.last  = in_empty || (col_wrap && row_wrap);
        s1_next.color = in_empty ? '0 : src_c;
        s1_next.depth = (in_empty || color_only) ? '0 : src_z;
        s1_next.cw    = !in_empty && !hit;
        s1_next.dw    = !in_empty && !hit && !color_only;

        // counters hold on an empty rectangle
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept && !in_empty) begin
            if (col_wrap) begin
                col_count_next = '0;
                row_count_next = row_wrap ? '0 : 10'(in_row + 10'd1);
            end else begin
                col_count_next = 10'(in_col + 10'd1);
            end
        end
    end

    // Product stage: plane bases and row offsets
    logic [1:0]  cmap;
    logic [1:0]  zmap;
    logic [11:0] hc;
    logic [11:0] hz;
    logic [11:0] ypos_row;

    always_comb begin
        if (pixel_type_reg >= bpwdt_pkg::PT_MAP_HI) begin
            cmap = 2'(pixel_type_reg - bpwdt_pkg::PT_MAP_HI);
            zmap = 2'd2;
        end else if (pixel_type_reg >= bpwdt_pkg::PT_MAP_LO) begin
            cmap = 2'(pixel_type_reg - bpwdt_pkg::PT_MAP_LO);
            zmap = 2'd3;
        end else begin
            cmap = 2'd0;
            zmap = 2'd1;
        end

        // height times plane number (0..3) by shift and add
        case (cmap)
            2'd0:    hc = '0;
            2'd1:    hc = {2'b00, frame_height_reg};
            2'd2:    hc = {1'b0, frame_height_reg, 1'b0};
            default: hc = {2'b00, frame_height_reg} + {1'b0, frame_height_reg, 1'b0};
        endcase
        case (zmap)
            2'd0:    hz = '0;
            2'd1:    hz = {2'b00, frame_height_reg};
            2'd2:    hz = {1'b0, frame_height_reg, 1'b0};
            default: hz = {2'b00, frame_height_reg} + {1'b0, frame_height_reg, 1'b0};
        endcase

        ypos_row = {1'b0, ypos} + {2'b00, s1_reg.row};

        s2_next.c_plane  = 23'(hc) * 23'(width);
        s2_next.z_plane  = 23'(hz) * 23'(width);
        s2_next.pos_prod = 23'(ypos_row) * 23'(width);
        s2_next.src_prod = 21'(s1_reg.row) * 21'(width);
        s2_next.col      = s1_reg.col;
        s2_next.empty    = s1_reg.empty;
        s2_next.last     = s1_reg.last;
        s2_next.color    = s1_reg.color;
        s2_next.depth    = s1_reg.depth;
        s2_next.cw       = s1_reg.cw;
        s2_next.dw       = s1_reg.dw;
    end

    // Output stage: address sums and source offset
    logic [bpwdt_pkg::SUM_W-1:0] pos_sum;
    logic [bpwdt_pkg::SUM_W-1:0] caddr_sum;
    logic [bpwdt_pkg::SUM_W-1:0] zaddr_sum;
    logic [21:0]                 src_sum;
    logic [ADDR_BITS-1:0]        caddr_reg, caddr_next;
    logic [ADDR_BITS-1:0]        zaddr_reg, zaddr_next;
    logic [22:0]                 soff_reg, soff_next;
    logic [15:0]                 color_reg;
    logic [15:0]                 depth_reg;
    logic                        cw_reg;
    logic                        dw_reg;
    logic                        last_reg;

    always_comb begin
        pos_sum    = bpwdt_pkg::SUM_W'(s2_reg.pos_prod) + bpwdt_pkg::SUM_W'(xpos)
                   + bpwdt_pkg::SUM_W'(s2_reg.col);
        caddr_sum  = bpwdt_pkg::SUM_W'(s2_reg.c_plane) + pos_sum;
        zaddr_sum  = bpwdt_pkg::SUM_W'(s2_reg.z_plane) + pos_sum;
        caddr_next = ADDR_BITS'(caddr_sum);
        zaddr_next = ADDR_BITS'(zaddr_sum);

        src_sum = 22'(s2_reg.src_prod) + 22'(s2_reg.col);
        if (s2_reg.empty || (source_mode_reg != bpwdt_pkg::SM_STEP)) begin
            soff_next = '0;
        end else if (color_only) begin
            soff_next = 23'(src_sum);
        end else begin
            soff_next = {src_sum, 1'b0};
        end
    end

    // Valid bits and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (adv) begin
                s1_valid_reg <= s_valid;
                s2_valid_reg <= s1_valid_reg;
                m_valid_reg  <= s2_valid_reg;
            end
        end
    end

    // Stage payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            caddr_reg <= caddr_next;
            zaddr_reg <= zaddr_next;
            soff_reg  <= soff_next;
            color_reg <= s2_reg.color;
            depth_reg <= s2_reg.depth;
            cw_reg    <= s2_reg.cw;
            dw_reg    <= s2_reg.dw;
            last_reg  <= s2_reg.last;
        end
    end

    assign m_color_address = caddr_reg[23:0];
    assign m_depth_address = zaddr_reg[23:0];
    assign m_source_offset = soff_reg;
    assign m_color_out     = color_reg;
    assign m_depth_out     = depth_reg;
    assign m_color_write   = cw_reg;
    assign m_depth_write   = dw_reg;
    assign m_last_pixel    = last_reg;

    // Checks
    // a depth write never happens without the colour write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_depth_write |-> m_color_write)
        else $error("depth write without colour write");

    // colour only mode leaves depth untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && color_only |-> !m_depth_write && (m_depth_out == '0))
        else $error("depth written in colour only mode");

    // finishing a rectangle returns both counters to the origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !in_empty && col_wrap && row_wrap
        |=> (col_count_reg == '0) && (row_count_reg == '0))
        else $error("counters not cleared at end of rectangle");

endmodule
